[rtl/assert_macros.svh]
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/asdo_pkg.sv]
package asdo_pkg;

    // Fixed field widths
    localparam int VW  = 6;   // vertex index
    localparam int DW  = 6;   // degree count
    localparam int CW  = 7;   // vertex count register

    localparam logic [CW-1:0] VCOUNT_RESET = 7'd64;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_ERASE = 2'd1,
        OP_QUERY = 2'd2,
        OP_ORDER = 2'd3
    } t_op;

    typedef struct packed {
        t_op           operation;
        logic [VW-1:0] first_vertex;
        logic [VW-1:0] second_vertex;
    } t_item;

    typedef struct packed {
        logic          edge_present;
        logic [VW-1:0] order_vertex;
        logic [DW-1:0] vertex_degree;
        logic          last;
    } t_result;

    // Sort key held by each cell
    typedef struct packed {
        logic          valid;
        logic [DW-1:0] deg;
        logic [VW-1:0] idx;
    } t_key;

    localparam t_key KEY_NONE = '{valid: 1'b0, deg: '0, idx: '0};

    // Commands broadcast to the cell row
    typedef enum logic [2:0] {
        CELL_NOP   = 3'd0,
        CELL_ADD   = 3'd1,
        CELL_ERASE = 3'd2,
        CELL_LOAD  = 3'd3,
        CELL_SORT  = 3'd4,
        CELL_SHIFT = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op      op;
        logic [VW-1:0] va;
        logic [VW-1:0] vb;
        logic [CW-1:0] n_eff;
        logic          phase;
    } t_cell_cmd;

    // Descending degree, then ascending index; unused vertices sink to the end
    function automatic logic key_better(t_key x, t_key y);
        return (x.valid && !y.valid) ||
               (x.valid && y.valid &&
                ((x.deg > y.deg) || ((x.deg == y.deg) && (x.idx < y.idx))));
    endfunction

endpackage

[rtl/asdo_cell.sv]
module asdo_cell #(
    parameter int NV  = 64,
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  asdo_pkg::t_cell_cmd i_cmd,
    input  asdo_pkg::t_key      i_left_key,
    input  asdo_pkg::t_key      i_right_key,
    output asdo_pkg::t_key      o_key,
    output logic                o_hit
);

    localparam int  IW        = (NV > 2) ? $clog2(NV) : 1;
    localparam bit  PAR       = (IDX % 2) == 1;
    localparam bit  HAS_LEFT  = IDX > 0;
    localparam bit  HAS_RIGHT = IDX < NV - 1;

    logic [NV-1:0]           r_row, n_row;
    logic [asdo_pkg::DW-1:0] r_deg, n_deg;
    asdo_pkg::t_key          r_key, n_key;
    logic                    match_a, match_b, vb_ok;

    assign match_a = i_cmd.va == asdo_pkg::VW'(IDX);
    assign match_b = i_cmd.vb == asdo_pkg::VW'(IDX);
    assign vb_ok   = {1'b0, i_cmd.vb} < asdo_pkg::CW'(NV);

    // This row's bit for the edge under test
    assign o_hit = match_a && vb_ok && r_row[i_cmd.vb[IW-1:0]];
    assign o_key = r_key;

    // Row, degree and sort key update
    always_comb begin
        n_row = r_row;
        n_deg = r_deg;
        n_key = r_key;
        case (i_cmd.op)
            asdo_pkg::CELL_ADD: begin
                if (match_a) begin
                    n_row[i_cmd.vb[IW-1:0]] = 1'b1;
                    n_deg = r_deg + 1'b1;
                end
                if (match_b) begin
                    n_row[i_cmd.va[IW-1:0]] = 1'b1;
                    n_deg = r_deg + 1'b1;
                end
            end
            asdo_pkg::CELL_ERASE: begin
                if (match_a) begin
                    n_row[i_cmd.vb[IW-1:0]] = 1'b0;
                    n_deg = r_deg - 1'b1;
                end
                if (match_b) begin
                    n_row[i_cmd.va[IW-1:0]] = 1'b0;
                    n_deg = r_deg - 1'b1;
                end
            end
            asdo_pkg::CELL_LOAD: begin
                n_key.valid = asdo_pkg::CW'(IDX) < i_cmd.n_eff;
                n_key.deg   = r_deg;
                n_key.idx   = asdo_pkg::VW'(IDX);
            end
            asdo_pkg::CELL_SORT: begin
                // odd-even transposition: left of a pair keeps the better key
                if (HAS_RIGHT && (PAR == i_cmd.phase)) begin
                    n_key = asdo_pkg::key_better(r_key, i_right_key) ? r_key : i_right_key;
                end else if (HAS_LEFT && (PAR != i_cmd.phase)) begin
                    n_key = asdo_pkg::key_better(i_left_key, r_key) ? r_key : i_left_key;
                end
            end
            asdo_pkg::CELL_SHIFT: begin
                n_key = i_right_key;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_deg <= '0;
        end else begin
            r_row <= n_row;
            r_deg <= n_deg;
        end
        r_key <= n_key;
    end

endmodule

[rtl/adjacency_store_degree_order.sv]
// Edge add and erase: busy while the item executes in S_EXEC; the next item is taken back in S_IDLE.
// Edge query: answer formed in S_EXEC and registered onto the result strobe; next item taken in S_IDLE.
// Order request: a load step, MAX_VERTICES odd-even sort phases, then one emit step per
// effective vertex; results are registered, busy ends as the last result appears.
// Synchronous reset clears the whole matrix and all degrees at once, vertex_count = 64.
module adjacency_store_degree_order #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  asdo_pkg::t_item          i_item,
    output logic                     o_result_valid,
    output asdo_pkg::t_result        o_result,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [asdo_pkg::CW-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SORT = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    asdo_pkg::t_item          r_item;
    logic [asdo_pkg::CW-1:0]  r_vcount;
    logic [asdo_pkg::CW-1:0]  r_cnt, n_cnt;
    logic                     r_res_valid, n_res_valid;
    asdo_pkg::t_result        r_result, n_result;
    logic [asdo_pkg::CW-1:0]  n_eff;
    logic                     in_use, distinct, edge_bit;
    asdo_pkg::t_cell_cmd      cmd;
    asdo_pkg::t_key           w_key [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]  w_hit;

    assign busy           = r_state != S_IDLE;
    assign o_cfg_ready    = r_state == S_IDLE;
    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

    // Effective vertex count, clamped to 1 .. MAX_VERTICES
    always_comb begin
        if (r_vcount == '0) begin
            n_eff = asdo_pkg::CW'(1);
        end else if (r_vcount > asdo_pkg::CW'(MAX_VERTICES)) begin
            n_eff = asdo_pkg::CW'(MAX_VERTICES);
        end else begin
            n_eff = r_vcount;
        end
    end

    assign in_use   = ({1'b0, r_item.first_vertex} < n_eff) &&
                      ({1'b0, r_item.second_vertex} < n_eff);
    assign distinct = r_item.first_vertex != r_item.second_vertex;
    assign edge_bit = |w_hit;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_res_valid = 1'b0;
        n_result    = r_result;
        cmd.op      = asdo_pkg::CELL_NOP;
        cmd.va      = r_item.first_vertex;
        cmd.vb      = r_item.second_vertex;
        cmd.n_eff   = n_eff;
        cmd.phase   = r_cnt[0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_item.operation)
                    asdo_pkg::OP_ADD: begin
                        if (in_use && distinct && !edge_bit) begin
                            cmd.op = asdo_pkg::CELL_ADD;
                        end
                    end
                    asdo_pkg::OP_ERASE: begin
                        if (in_use && distinct && edge_bit) begin
                            cmd.op = asdo_pkg::CELL_ERASE;
                        end
                    end
                    asdo_pkg::OP_QUERY: begin
                        n_res_valid            = 1'b1;
                        n_result.edge_present  = in_use && distinct && edge_bit;
                        n_result.order_vertex  = '0;
                        n_result.vertex_degree = '0;
                        n_result.last          = 1'b1;
                    end
                    asdo_pkg::OP_ORDER: begin
                        cmd.op  = asdo_pkg::CELL_LOAD;
                        n_cnt   = '0;
                        n_state = S_SORT;
                    end
                    default: begin
                    end
                endcase
            end
            S_SORT: begin
                cmd.op = asdo_pkg::CELL_SORT;
                if (r_cnt == asdo_pkg::CW'(MAX_VERTICES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EMIT: begin
                // best key sits in cell 0; the row shifts one place per result
                cmd.op                 = asdo_pkg::CELL_SHIFT;
                n_res_valid            = 1'b1;
                n_result.edge_present  = 1'b0;
                n_result.order_vertex  = w_key[0].idx;
                n_result.vertex_degree = w_key[0].deg;
                n_result.last          = (r_cnt + 1'b1) == n_eff;
                n_cnt                  = r_cnt + 1'b1;
                if ((r_cnt + 1'b1) == n_eff) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
            r_vcount    <= asdo_pkg::VCOUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
        end
        r_result <= n_result;
        if (start && !busy) begin
            r_item <= i_item;
        end
    end

    // Row of vertex cells
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        asdo_pkg::t_key left_key, right_key;
        if (g == 0) begin : g_first
            assign left_key = asdo_pkg::KEY_NONE;
        end else begin : g_mid_l
            assign left_key = w_key[g-1];
        end
        if (g == MAX_VERTICES - 1) begin : g_last
            assign right_key = asdo_pkg::KEY_NONE;
        end else begin : g_mid_r
            assign right_key = w_key[g+1];
        end
        asdo_cell #(
            .NV  (MAX_VERTICES),
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_left_key  (left_key),
            .i_right_key (right_key),
            .o_key       (w_key[g]),
            .o_hit       (w_hit[g])
        );
    end

endmodule

[rtl/asdo_checker.sv]
`include "assert_macros.svh"

module asdo_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_result_valid,
    input asdo_pkg::t_result        o_result,
    input logic                     o_cfg_ready
);

    // an accepted item always makes the block busy in the cycle after acceptance
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // results only come out of work that was under way
    `ASSERT_IMPLIES(a_result_from_work, i_clk, i_rst_n, o_result_valid, $past(busy))

    // an order run streams without gaps until its last item
    `ASSERT_NEXT(a_run_contiguous, i_clk, i_rst_n, o_result_valid && !o_result.last,
        o_result_valid)

    // a query answer that reports an edge is a single item with no vertex fields
    `ASSERT_IMPLIES(a_query_shape, i_clk, i_rst_n, o_result_valid && o_result.edge_present,
        o_result.last && (o_result.order_vertex == '0) && (o_result.vertex_degree == '0))

    // configuration is taken only while no item is at work
    `ASSERT_IMPLIES(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready, !busy)

endmodule

bind adjacency_store_degree_order asdo_checker u_asdo_checker (.*);
